### hw/rtl/median_filter_3x3_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 median filter
// Concurrent assertion wrappers clocked on clk_i, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_FILTER_3X3_TOP_MACROS_SVH
`define MEDIAN_FILTER_3X3_TOP_MACROS_SVH

// Checked only while the block is out of reset.
`define MF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define MF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hw/rtl/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// Constants, types and the median network of the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int MaxWidth   = 1024;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int EffW       = ColW + 1;
  localparam int PixW       = 8;
  localparam int CfgWidthW  = 11;
  localparam int CfgHeightW = 16;
  localparam int CfgDataW   = 16;
  localparam int CfgIdxW    = 1;
  localparam int RowW       = 16;
  localparam int PosW       = 26;
  localparam int AreaW      = EffW + CfgHeightW;
  localparam int MinWidth   = 3;
  localparam int MinHeight  = 3;
  localparam int WinCenter  = 4;

  localparam int ResetWidth  = 1024;
  localparam int ResetHeight = 480;
  localparam int ResetEffW   = (ResetWidth < MinWidth) ? MinWidth :
                               (ResetWidth > MaxWidth) ? MaxWidth : ResetWidth;
  localparam int ResetEffH   = (ResetHeight < MinHeight) ? MinHeight : ResetHeight;
  localparam int ResetArea   = ResetEffW * ResetEffH;

  typedef logic [PixW-1:0] pix_t;
  typedef logic [8:0][PixW-1:0] win_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 1'b0,
    CfgImageHeight = 1'b1
  } cfg_reg_e;

  // One line store entry holds the pixel two rows up and the one a row up.
  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } line_ent_t;

  typedef struct packed {
    logic [ColW-1:0] col;
    pix_t            pix;
    logic            primed;
    logic            border;
    logic            fin;
    logic            fwd;
  } s1_meta_t;

  typedef struct packed {
    logic border;
    logic fin;
  } s2_meta_t;

  function automatic pix_t min2(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(pix_t a, pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // Sort each row, then the median is the median of the largest row minimum,
  // the median of the row medians and the smallest row maximum.
  function automatic pix_t median9(win_t w);
    pix_t lo [3];
    pix_t md [3];
    pix_t hi [3];
    for (int r = 0; r < 3; r++) begin
      lo[r] = min2(min2(w[3*r], w[3*r+1]), w[3*r+2]);
      hi[r] = max2(max2(w[3*r], w[3*r+1]), w[3*r+2]);
      md[r] = med3(w[3*r], w[3*r+1], w[3*r+2]);
    end
    return med3(max2(max2(lo[0], lo[1]), lo[2]),
                med3(md[0], md[1], md[2]),
                min2(min2(hi[0], hi[1]), hi[2]));
  endfunction

endpackage

### hw/rtl/median_filter_3x3_top.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_top
// Streaming 3x3 median filter over a raster of 8-bit greyscale pixels.
// ----------------------------------------------------------------------------
// Usage. Pixels enter in raster order on the input channel (in_valid_i /
// in_stall_o); a beat with flush_i set carries no pixel and acts as a zero
// pixel. Results leave on the output channel (out_valid_o / out_stall_i).
// Interior pixels get the median of their 3x3 window; the first and last row
// and column are copied. frame_end_o marks the last pixel of a frame.
// The output runs image_width+1 input beats behind, so the host sends
// image_width+1 flush beats after the last pixel to drain a frame.
// Throughput is one beat per clock while the receiver does not stall. A result
// follows the input beat that causes it through the line store read, the window
// update, then the median network into the output register.
// Configuration (image_width, image_height) is written through cfg_we_i while
// the block is idle; the clamped width and frame limits are registered from the configuration registers.
// Reset clears the counters, the window and the pipeline; the line stores
// keep whatever they hold and need no clearing pass.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_stall_o rises in the same cycle; no beat is lost or repeated.
// ----------------------------------------------------------------------------
`include "median_filter_3x3_top_macros.svh"

module median_filter_3x3_top
  import mf3_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [PixW-1:0]     in_pixel_i,
  input  logic                flush_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PixW-1:0]     out_pixel_o,
  output logic                frame_end_o
);

  // Configuration registers and the limits derived from them.
  logic [CfgWidthW-1:0]  width_q;
  logic [CfgHeightW-1:0] height_q;
  logic [EffW-1:0]       eff_w_d, eff_w_q;
  logic [CfgHeightW-1:0] eff_h;
  logic [AreaW-1:0]      area;
  logic [PosW-1:0]       lim_end_d, lim_end_q;
  logic [PosW-1:0]       lim_last_d, lim_last_q;

  // Input side counters.
  logic [ColW-1:0] col_d, col_q;
  logic [RowW-1:0] row_d, row_q;
  logic [PosW-1:0] pos_d, pos_q;

  // Pipeline.
  logic      en, acc;
  logic [ColW-1:0] col;
  pix_t      pix;
  logic      primed, border, fin, col_last, fwd;
  logic      s1_valid_q;
  s1_meta_t  s1_q;
  line_ent_t rd_ent_q, fwd_ent_q, ent, wr_ent;
  line_ent_t line_mem [MaxWidth];
  win_t      win_q;
  logic      s2_valid_q;
  s2_meta_t  s2_q;
  logic      out_valid_q;
  pix_t      out_pixel_q;
  logic      frame_end_q;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgWidthW'(ResetWidth);
      height_q <= CfgHeightW'(ResetHeight);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgImageWidth:  width_q  <= cfg_wdata_i[CfgWidthW-1:0];
        CfgImageHeight: height_q <= cfg_wdata_i[CfgHeightW-1:0];
      endcase
    end
  end

  always_comb begin
    if (width_q < CfgWidthW'(MinWidth)) begin
      eff_w_d = EffW'(MinWidth);
    end else if (32'(width_q) > MaxWidth) begin
      eff_w_d = EffW'(MaxWidth);
    end else begin
      eff_w_d = EffW'(width_q);
    end
    eff_h      = (height_q < CfgHeightW'(MinHeight)) ? CfgHeightW'(MinHeight) : height_q;
    area       = AreaW'(eff_w_d) * AreaW'(eff_h);
    lim_end_d  = PosW'(area - AreaW'(1));
    lim_last_d = PosW'(area - AreaW'(eff_w_d));
  end

  // The limits are registered so the multiplier stays off the pixel path.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q    <= EffW'(ResetEffW);
      lim_end_q  <= PosW'(ResetArea - 1);
      lim_last_q <= PosW'(ResetArea - ResetEffW);
    end else begin
      eff_w_q    <= eff_w_d;
      lim_end_q  <= lim_end_d;
      lim_last_q <= lim_last_d;
    end
  end

  // ---------------------------------------------------------- accept stage
  // The pipeline moves as one whenever the output register can take a beat.
  assign en         = !(out_valid_q && out_stall_i);
  assign acc        = in_valid_i && en;
  assign in_stall_o = !en;

  // All position bookkeeping is settled here; later stages only move data.
  always_comb begin
    col      = (EffW'(col_q) >= eff_w_q) ? '0 : col_q;
    pix      = flush_i ? '0 : in_pixel_i;
    primed   = (row_q >= RowW'(2)) || ((row_q == RowW'(1)) && (col != '0));
    col_last = (EffW'(col) + EffW'(1)) >= eff_w_q;
    border   = (col == ColW'(0)) || (col == ColW'(1)) ||
               (pos_q < PosW'(eff_w_q)) || (pos_q >= lim_last_q);
    fin      = pos_q >= lim_end_q;
    // The next beat reads the entry that the beat in stage one writes now.
    fwd      = s1_valid_q && (col == s1_q.col);

    col_d = col_q;
    row_d = row_q;
    pos_d = pos_q;
    if (acc) begin
      if (col_last) begin
        col_d = '0;
        if (row_q != '1) begin
          row_d = row_q + RowW'(1);
        end
      end else begin
        col_d = col + ColW'(1);
      end
      if (primed) begin
        if (fin) begin
          col_d = '0;
          row_d = '0;
          pos_d = '0;
        end else begin
          pos_d = pos_q + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      pos_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      pos_q <= pos_d;
    end
  end

  // ------------------------------------------------------ stage one: lines
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q      <= '{col: col, pix: pix, primed: primed, border: border,
                     fin: fin, fwd: fwd};
      fwd_ent_q <= wr_ent;
    end
  end

  // Both line stores share one memory: each entry shifts up by one row.
  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_ent_q <= line_mem[col];
    end
    if (en && s1_valid_q) begin
      line_mem[s1_q.col] <= wr_ent;
    end
  end

  assign ent    = s1_q.fwd ? fwd_ent_q : rd_ent_q;
  assign wr_ent = '{upper: ent.middle, middle: s1_q.pix};

  // ----------------------------------------------------- stage two: window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= '0;
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q && s1_q.primed;
      if (s1_valid_q) begin
        for (int r = 0; r < 3; r++) begin
          win_q[3*r]   <= win_q[3*r+1];
          win_q[3*r+1] <= win_q[3*r+2];
        end
        win_q[2] <= ent.upper;
        win_q[5] <= ent.middle;
        win_q[8] <= s1_q.pix;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q <= '{border: s1_q.border, fin: s1_q.fin};
    end
  end

  // ------------------------------------------------- stage three: result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s2_valid_q) begin
      out_pixel_q <= s2_q.border ? win_q[WinCenter] : median9(win_q);
      frame_end_q <= s2_q.fin;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = out_pixel_q;
  assign frame_end_o = frame_end_q;

  // ------------------------------------------------------------ assertions
  `MF_ASSERT(a_frame_restart, (acc && primed && fin) |=> (col_q == '0 && row_q == '0 && pos_q == '0), "counters did not restart after the last pixel of a frame")
  `MF_ASSERT(a_window_holds, (!en) |=> $stable(win_q), "window moved while the pipeline was stalled")
  `MF_ASSERT(a_result_source, $rose(out_valid_q) |-> $past(s2_valid_q), "result appeared without a primed beat behind it")
  `MF_ASSERT_ALWAYS(a_reset_quiet, (!rst_ni) |-> (!out_valid_o && !s2_valid_q && !s1_valid_q), "pipeline not empty during reset")

endmodule

### verif/median_filter_3x3_checker.sv
// ----------------------------------------------------------------------------
// Median filter result checker
// Watches the register port and both channels of the 3x3 median filter,
// predicts each filtered pixel and compares it with the output beat.
// ----------------------------------------------------------------------------
module median_filter_3x3_checker
  import mf3_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [PixW-1:0]     in_pixel_i,
  input  logic                flush_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [PixW-1:0]     out_pixel_i,
  input  logic                frame_end_i,
  output int unsigned         fail_count_o,
  output int unsigned         due_count_o
);

  typedef struct packed {
    pix_t pixel;
    logic last;
  } filtered_px_t;

  // Shadow copy of the filter state.
  bit [CfgWidthW-1:0]  width_reg;
  bit [CfgHeightW-1:0] height_reg;
  bit [PixW-1:0]       upper_row [MaxWidth];
  bit [PixW-1:0]       middle_row [MaxWidth];
  bit [PixW-1:0]       win [9];
  bit [ColW-1:0]       col_q;
  bit [RowW-1:0]       row_q;
  bit [PosW-1:0]       pos_q;

  filtered_px_t due_px [$];

  function automatic bit [PixW-1:0] middle_of_nine(input bit [PixW-1:0] v [9]);
    bit [PixW-1:0] x;
    int            j;
    for (int i = 1; i < 9; i++) begin
      x = v[i];
      j = i - 1;
      while (j >= 0 && v[j] > x) begin
        v[j + 1] = v[j];
        j--;
      end
      v[j + 1] = x;
    end
    return v[WinCenter];
  endfunction

  // Advances the shadow state by one input beat and queues the pixel it
  // releases, if any.
  task automatic advance_window(input pix_t px_in, input logic fl);
    int unsigned   w;
    int unsigned   h;
    int unsigned   c;
    int unsigned   q;
    bit [PixW-1:0] px;
    bit [PixW-1:0] up;
    bit [PixW-1:0] mid;
    bit [PixW-1:0] val;
    bit            primed;
    bit            border;
    bit            last;
    filtered_px_t  due_item;
    w = width_reg;
    if (w < MinWidth) w = MinWidth;
    if (w > MaxWidth) w = MaxWidth;
    h = height_reg;
    if (h < MinHeight) h = MinHeight;
    c = col_q;
    if (c >= w) c = 0;

    px  = fl ? '0 : px_in;
    up  = upper_row[c];
    mid = middle_row[c];
    upper_row[c]  = mid;
    middle_row[c] = px;

    for (int r = 0; r < 3; r++) begin
      win[3*r]     = win[3*r + 1];
      win[3*r + 1] = win[3*r + 2];
    end
    win[2] = up;
    win[5] = mid;
    win[8] = px;

    primed = (row_q >= 2) || (row_q == 1 && c >= 1);
    if (c + 1 >= w) begin
      col_q = '0;
      if (row_q != '1) row_q++;
    end else begin
      col_q = ColW'(c + 1);
    end

    if (primed) begin
      q      = pos_q;
      border = (c == 0) || (c == 1) || (q < w) || (q >= w * (h - 1));
      val    = border ? win[WinCenter] : middle_of_nine(win);
      last   = (q >= w * h - 1);
      if (last) begin
        col_q = '0;
        row_q = '0;
        pos_q = '0;
      end else begin
        pos_q = PosW'(q + 1);
      end
      due_item.pixel = val;
      due_item.last  = last;
      due_px = {due_px, due_item};
    end
  endtask

  // Every mismatch gets one line and is counted.
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH at %0t: %s: got %0d, expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    filtered_px_t want;
    if (!rst_ni) begin
      width_reg  = CfgWidthW'(ResetWidth);
      height_reg = CfgHeightW'(ResetHeight);
      for (int k = 0; k < 9; k++) win[k] = '0;
      col_q = '0;
      row_q = '0;
      pos_q = '0;
      due_px.delete();
      due_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgImageWidth:  width_reg  = cfg_wdata_i[CfgWidthW-1:0];
          CfgImageHeight: height_reg = cfg_wdata_i[CfgHeightW-1:0];
          default: ;
        endcase
      end
      // Compare before the new input beat is taken in: a result never
      // belongs to a beat accepted at the same edge.
      if (out_valid_i && !out_stall_i) begin
        if (due_px.size() == 0) begin
          report_mismatch("result beat with none due, out_pixel", out_pixel_i, 0);
        end else begin
          want = due_px.pop_front();
          if (out_pixel_i !== want.pixel) begin
            report_mismatch("out_pixel", out_pixel_i, want.pixel);
          end
          if (frame_end_i !== want.last) begin
            report_mismatch("frame_end", frame_end_i, want.last);
          end
        end
      end
      if (in_valid_i && !in_stall_i) advance_window(in_pixel_i, flush_i);
      due_count_o = due_px.size();
    end
  end

endmodule

### verif/tb_median_filter_3x3_top.sv
// ----------------------------------------------------------------------------
// Testbench for the 3x3 median filter
// Streams frames of many sizes through the filter with random idling on both
// channels; a checker beside the block predicts every result beat.
// ----------------------------------------------------------------------------
module tb_median_filter_3x3_top;
  import mf3_pkg::*;

  // Clock edges waited after the last due result before the block counts as
  // idle.
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned DrainLimit  = 20000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned RandomBeats = 420;
  // Watchdog limit in time units, well above the slowest correct run.
  localparam int unsigned TimeoutUnits = 2000000;

  // Geometry of the mid-frame width change: a frame of OldW x OldH is cut
  // after ShrinkAt beats, with the column past the new width.
  localparam int unsigned OldW     = 8;
  localparam int unsigned OldH     = 6;
  localparam int unsigned ShrinkAt = 22;
  localparam int unsigned NewW     = 4;
  localparam int unsigned NewH     = 4;

  typedef enum int unsigned {
    TexNoise,
    TexExtremes,
    TexFlat,
    TexSpeckle
  } texture_e;

  logic                clk       = 1'b0;
  logic                rst_n;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [PixW-1:0]     in_pixel  = '0;
  logic                flush     = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [PixW-1:0]     out_pixel;
  logic                frame_end;

  int unsigned errors;
  int unsigned pending;

  // Frame geometry as the block sees it after clamping, and the position of
  // the next input beat within the frame, drain beats included.
  int unsigned cur_w       = ResetEffW;
  int unsigned cur_h       = ResetEffH;
  int unsigned frame_len   = ResetEffW * ResetEffH + ResetEffW + 1;
  int unsigned frame_phase = 0;

  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int unsigned hold_reqs  = 0;
  int unsigned holds_done = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  median_filter_3x3_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_pixel_i  (in_pixel),
    .flush_i     (flush),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_pixel_o (out_pixel),
    .frame_end_o (frame_end)
  );

  median_filter_3x3_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_pixel_i   (in_pixel),
    .flush_i      (flush),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_pixel_i  (out_pixel),
    .frame_end_i  (frame_end),
    .fail_count_o (errors),
    .due_count_o  (pending)
  );

  // Mostly short idle stretches, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one input beat, after an optional idle gap, and returns once the
  // block has taken it. Everything is driven on the falling edge; the stall
  // is sampled at the rising edge, where the beat is accepted.
  task automatic send_beat(input pix_t p, input logic f);
    int unsigned gap;
    gap = tx_idle_en ? idle_len() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_pixel <= p;
    flush    <= f;
    do @(posedge clk); while (in_stall);
    frame_phase = (frame_phase + 1) % frame_len;
  endtask

  // Stops offering beats until every predicted result has left the block,
  // then lets the pipeline run empty of beats that release nothing.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Finishes the frame in progress with flush beats, waits for the block to
  // go idle and programs a new geometry. The raw values may lie outside the
  // legal range; the block clamps them.
  task automatic set_geometry(input logic [CfgDataW-1:0] w_raw,
                              input logic [CfgDataW-1:0] h_raw);
    while (frame_phase != 0) send_beat(pix_t'($urandom_range(255)), 1'b1);
    wait_drained();
    write_reg(CfgImageWidth, w_raw);
    write_reg(CfgImageHeight, h_raw);
    // The clamped limits are registered from the configuration registers.
    repeat (2) @(negedge clk);
    cur_w = w_raw[CfgWidthW-1:0];
    if (cur_w < MinWidth) cur_w = MinWidth;
    else if (cur_w > MaxWidth) cur_w = MaxWidth;
    cur_h = h_raw;
    if (cur_h < MinHeight) cur_h = MinHeight;
    frame_len = cur_w * cur_h + cur_w + 1;
  endtask

  // One complete frame: every pixel of the current geometry, then the
  // width+1 drain beats that push the last results out.
  task automatic send_frame(input texture_e tex);
    int unsigned n;
    int unsigned base;
    pix_t        p;
    base = $urandom_range(255);
    for (n = 0; n < cur_w * cur_h; n++) begin
      case (tex)
        TexExtremes: p = $urandom_range(1) ? 8'hFF : 8'h00;
        TexFlat:     p = pix_t'(base + $urandom_range(3));
        TexSpeckle: begin
          if ($urandom_range(99) < 15) p = $urandom_range(1) ? 8'hFF : 8'h00;
          else p = pix_t'(base);
        end
        default:     p = pix_t'($urandom_range(255));
      endcase
      // A rare flush inside the frame stands for a black pixel.
      send_beat(p, $urandom_range(99) < 3);
    end
    // Drain beats are mostly flushes; a pixel beat here must be ignored.
    for (n = 0; n <= cur_w; n++) begin
      send_beat(pix_t'($urandom_range(255)), $urandom_range(99) < 70);
    end
  endtask

  // Output side. Stall runs of random length alternate with free stretches;
  // a hold request from the stimulus turns into one long stall, counted here.
  initial begin : rx_side
    int unsigned run;
    forever begin
      if (holds_done != hold_reqs) begin
        run = HoldCycles;
        holds_done++;
      end else begin
        run = rx_idle_en ? idle_len() : 0;
      end
      repeat (run) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
  end

  // Stimulus: directed frames first, then random frames and noise bursts.
  initial begin : stimulus
    int unsigned            n;
    int unsigned            roll;
    int unsigned            w;
    int unsigned            random_beats;
    logic [CfgDataW-1:0]    w_raw;
    logic [CfgDataW-1:0]    h_raw;

    random_beats = 0;
    rst_n <= 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Smallest frame, both registers written below range. A checkerboard of
    // black and white; the one interior pixel sees five whites. The drain
    // mixes flush beats with pixel beats that must not show up anywhere.
    set_geometry(16'h0002, 16'h0000);
    for (n = 0; n < 9; n++) send_beat(n[0] ? 8'h00 : 8'hFF, 1'b0);
    send_beat(8'hFF, 1'b1);
    send_beat(8'h5A, 1'b0);
    send_beat(8'h00, 1'b1);
    send_beat(8'hA5, 1'b0);

    // Width written with junk in the bits above the register. An early
    // flush sits on an interior pixel and must act as a zero pixel.
    set_geometry(16'hF805, 16'h0004);
    for (n = 0; n < 20; n++) begin
      if (n == 7) send_beat(8'hAA, 1'b1);
      else send_beat(pix_t'(n * 53 + 17), 1'b0);
    end
    for (n = 0; n < 6; n++) send_beat(8'h3C, 1'b1);

    // Back pressure: the receiver holds off for a long stretch while the
    // sender keeps offering beats, so the block fills and stalls its input.
    set_geometry(16'd10, 16'd6);
    tx_idle_en = 1'b0;
    hold_reqs++;
    send_frame(TexNoise);
    tx_idle_en = 1'b1;

    // Width change in the middle of a frame, with the block idle. Two full
    // rows are in the line stores, so every column of the narrower frame has
    // been written. The input column lies past the new width and must count
    // as zero; the frame then ends after the remaining results.
    set_geometry(16'(OldW), 16'(OldH));
    for (n = 0; n < ShrinkAt; n++) send_beat(pix_t'($urandom_range(255)), 1'b0);
    wait_drained();
    write_reg(CfgImageWidth, 16'(NewW));
    write_reg(CfgImageHeight, 16'(NewH));
    repeat (2) @(negedge clk);
    cur_w     = NewW;
    cur_h     = NewH;
    frame_len = NewW * NewH + NewW + 1;
    repeat (NewW * NewH - (ShrinkAt - OldW - 1)) begin
      send_beat(pix_t'($urandom_range(255)), 1'b0);
    end
    frame_phase = 0;

    // A frame run back to back without idling on either side, with the
    // height written below range.
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    set_geometry(16'd12, 16'h0001);
    send_frame(TexSpeckle);

    // Random part. Mostly whole frames of small size with varied texture;
    // sometimes a burst that ignores frame boundaries, so later frames start
    // anywhere in the block's raster.
    set_geometry(16'd6, 16'd5);
    while (random_beats < RandomBeats) begin
      if ($urandom_range(99) < 30) begin
        roll = $urandom_range(99);
        if (roll < 75) w = $urandom_range(3, 12);
        else if (roll < 88) w = $urandom_range(0, 2);
        else w = $urandom_range(13, 40);
        // Bits above the width register are don't-care for the block.
        w_raw = CfgDataW'(($urandom_range(31) << CfgWidthW) | w);
        if ($urandom_range(99) < 80) h_raw = CfgDataW'($urandom_range(3, 8));
        else h_raw = CfgDataW'($urandom_range(0, 2));
        set_geometry(w_raw, h_raw);
      end
      tx_idle_en = ($urandom_range(99) < 80);
      rx_idle_en = ($urandom_range(99) < 80);
      if ($urandom_range(99) < 15) begin
        n = $urandom_range(1, 2 * cur_w);
        random_beats += n;
        repeat (n) send_beat(pix_t'($urandom_range(255)), $urandom_range(1));
      end else begin
        send_frame(texture_e'($urandom_range(3)));
        random_beats += frame_len;
      end
      // Now and then the sender pauses until every result has come back.
      if ($urandom_range(99) < 20) wait_drained();
    end

    // Wait for the outstanding results, then give the block time to show
    // any result beat that nobody asked for.
    @(negedge clk);
    in_valid <= 1'b0;
    for (n = 0; n < DrainLimit && pending != 0; n++) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutUnits);
    $display("Mismatches found");
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/mf3_pkg.sv
hw/rtl/median_filter_3x3_top.sv
verif/median_filter_3x3_checker.sv
verif/tb_median_filter_3x3_top.sv
